// ===== rtl/ilffa_pkg.sv =====
// Shared constants and types for the implicit-list first-fit allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package ilffa_pkg;

  localparam int unsigned HEAP_UNITS = 4096;
  localparam int unsigned UNIT_W     = $clog2(HEAP_UNITS);
  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned TAG_W      = LEN_W + 1;
  localparam int unsigned PTR_W      = LEN_W + 1;
  localparam int unsigned BRK_W      = 13;
  localparam int unsigned SIZE_SUM_W = ADDR_W + 1;

  // Header plus rounding slack: ceil((size + 4) / 8) = (size + 11) >> 3.
  localparam logic [SIZE_SUM_W-1:0] ROUND_ADD = SIZE_SUM_W'(4 + 7);
  localparam logic [2:0]            PAY_OFS   = 3'd4;
  localparam logic [PTR_W-1:0]      HEAP_LIM  = PTR_W'(HEAP_UNITS);

  typedef enum logic [1:0] {
    RD_P    = 2'd0,
    RD_Q    = 2'd1,
    RD_UNIT = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_FREE   = 2'd0,
    RES_FIT    = 2'd1,
    RES_APPEND = 2'd2
  } res_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    walk_step;
    logic    merge_start;
    logic    merge_step;
    logic    merge_end;
    logic    append;
    logic    free_wr;
    logic    res_load;
    res_e    res_kind;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic p_in_range;
    logic q_in_range;
    logic tag_free;
    logic fits;
    logic free_ok;
  } sts_t;

endpackage

// ===== rtl/ilffa_dp.sv =====
// Datapath of the allocator: tag memory, walk pointers, break register and result word.
// Depends on ilffa_pkg; driven by commands from ilffa_ctrl.
module ilffa_dp import ilffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              func_i,
  input  logic [ADDR_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] block_address_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              status_o,
  output logic [ADDR_W-1:0] payload_address_o
);

  logic [TAG_W-1:0]  tag_mem [HEAP_UNITS];
  logic [TAG_W-1:0]  rd_q;
  logic [BRK_W-1:0]  brk_q, brk_d;
  logic [PTR_W-1:0]  p_q, q_q, base_q, sum_q;
  logic [LEN_W-1:0]  need_q;
  logic [UNIT_W-1:0] unit_q;
  logic              free_ok_q;
  logic              status_q;
  logic [ADDR_W-1:0] payload_q;

  logic [SIZE_SUM_W-1:0] size_sum;
  logic [LEN_W-1:0]      need_d;
  logic [LEN_W-1:0]      cur_len;
  logic [UNIT_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [UNIT_W-1:0]     wr_addr;
  logic [TAG_W-1:0]      wr_data;
  logic [PTR_W-1:0]      brk_need;
  logic                  fits;
  logic [UNIT_W-1:0]     req_unit;

  assign size_sum = SIZE_SUM_W'(request_size_i) + ROUND_ADD;
  assign need_d   = size_sum[SIZE_SUM_W-1:3];
  assign req_unit = block_address_i[ADDR_W-1:3];

  // A zero-length tag counts as one unit so that the walk always moves on.
  assign cur_len  = (rd_q[TAG_W-1:1] == '0) ? LEN_W'(1) : rd_q[TAG_W-1:1];
  assign fits     = (sum_q >= PTR_W'(need_q));
  assign brk_need = PTR_W'(brk_q) + PTR_W'(need_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_P:    rd_addr = p_q[UNIT_W-1:0];
      RD_Q:    rd_addr = q_q[UNIT_W-1:0];
      RD_UNIT: rd_addr = unit_q;
      default: rd_addr = p_q[UNIT_W-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base_q[UNIT_W-1:0];
    wr_data = {sum_q[LEN_W-1:0], fits};
    if (cmd_i.merge_end) begin
      wr_en = 1'b1;
    end else if (cmd_i.append && (brk_need < HEAP_LIM)) begin
      wr_en   = 1'b1;
      wr_addr = brk_q[UNIT_W-1:0];
      wr_data = {need_q, 1'b1};
    end else if (cmd_i.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = unit_q;
      wr_data = {rd_q[TAG_W-1:1], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= tag_mem[rd_addr];
    end
  end

  always_comb begin
    brk_d = brk_q;
    if (cmd_i.append && (brk_need < HEAP_LIM)) begin
      brk_d = brk_need[BRK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q <= '0;
    end else begin
      brk_q <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      need_q    <= need_d;
      unit_q    <= req_unit;
      free_ok_q <= (block_address_i[2:0] == PAY_OFS) && (BRK_W'(req_unit) < brk_q);
      p_q       <= '0;
    end
    if (cmd_i.walk_step) begin
      p_q <= p_q + PTR_W'(cur_len);
    end
    if (cmd_i.merge_start) begin
      base_q <= p_q;
      sum_q  <= PTR_W'(cur_len);
      q_q    <= p_q + PTR_W'(cur_len);
    end
    if (cmd_i.merge_step) begin
      sum_q <= sum_q + PTR_W'(cur_len);
      q_q   <= q_q + PTR_W'(cur_len);
    end
    if (cmd_i.merge_end) begin
      p_q <= base_q + sum_q;
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        RES_FREE: begin
          status_q  <= 1'b0;
          payload_q <= '0;
        end
        RES_FIT: begin
          status_q  <= 1'b0;
          payload_q <= {base_q[UNIT_W-1:0], PAY_OFS};
        end
        RES_APPEND: begin
          status_q  <= (brk_need >= HEAP_LIM);
          payload_q <= (brk_need >= HEAP_LIM) ? '0 : {brk_q[UNIT_W-1:0], PAY_OFS};
        end
        default: begin
          status_q  <= 1'b0;
          payload_q <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.req_free   = func_i;
    sts_o.p_in_range = (p_q < PTR_W'(brk_q)) && (p_q < HEAP_LIM);
    sts_o.q_in_range = (q_q < PTR_W'(brk_q)) && (q_q < HEAP_LIM);
    sts_o.tag_free   = ~rd_q[0];
    sts_o.fits       = fits;
    sts_o.free_ok    = free_ok_q;
  end

  assign status_o          = status_q;
  assign payload_address_o = payload_q;

endmodule

// ===== rtl/ilffa_ctrl.sv =====
// Controller state machine of the allocator: sequences walks, merges, appends and frees.
// Depends on ilffa_pkg; commands ilffa_dp and owns both handshakes.
module ilffa_ctrl import ilffa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_WALK_RD   = 10'b0000000010,
    S_WALK_EV   = 10'b0000000100,
    S_MERGE_RD  = 10'b0000001000,
    S_MERGE_EV  = 10'b0000010000,
    S_MERGE_END = 10'b0000100000,
    S_APPEND    = 10'b0001000000,
    S_FREE_RD   = 10'b0010000000,
    S_FREE_WR   = 10'b0100000000,
    S_FREE_FIN  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_fin;

  // The result register can take a new word when it is empty or being drained.
  assign can_fin = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel   = RD_P;
    cmd_o.res_kind = RES_FREE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.req_free ? S_FREE_RD : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.p_in_range) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_WALK_EV;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_WALK_EV: begin
        if (sts_i.tag_free) begin
          cmd_o.merge_start = 1'b1;
          state_d = S_MERGE_RD;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = S_WALK_RD;
        end
      end
      S_MERGE_RD: begin
        if (sts_i.q_in_range) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_Q;
          state_d = S_MERGE_EV;
        end else begin
          state_d = S_MERGE_END;
        end
      end
      S_MERGE_EV: begin
        if (sts_i.tag_free) begin
          cmd_o.merge_step = 1'b1;
          state_d = S_MERGE_RD;
        end else begin
          state_d = S_MERGE_END;
        end
      end
      S_MERGE_END: begin
        if (!sts_i.fits) begin
          cmd_o.merge_end = 1'b1;
          state_d = S_WALK_RD;
        end else if (can_fin) begin
          cmd_o.merge_end = 1'b1;
          cmd_o.res_load  = 1'b1;
          cmd_o.res_kind  = RES_FIT;
          state_d = S_IDLE;
        end
      end
      S_APPEND: begin
        if (can_fin) begin
          cmd_o.append   = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_APPEND;
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: begin
        if (sts_i.free_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_UNIT;
          state_d = S_FREE_WR;
        end else begin
          state_d = S_FREE_FIN;
        end
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d = S_FREE_FIN;
      end
      S_FREE_FIN: begin
        if (can_fin) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_FREE;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/implicit_list_first_fit_allocator.sv =====
// Top level of the implicit-list first-fit heap allocator.
// Depends on ilffa_pkg, ilffa_ctrl and ilffa_dp.
//
//   channel | handshake               | word
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | func_i, request_size_i, block_address_i
//   out     | out_valid_o/out_ready_i | status_o, payload_address_o
//
// A free passes through its read, write and finish states before its result
// is loaded; an ignored free skips the write state.
// An allocation reads the tag memory and then evaluates the tag for every
// block header it visits, merges free neighbours and finishes with a fit or
// an append; the single read port of the tag memory keeps read and evaluate apart.
// Reset clears the controller and the break register only; the tag memory
// holds no reset value and needs no clearing pass, since the walk only
// visits block headers below the break, all of which have been written.
// While a result word waits for out_ready_i, the next word may already be
// accepted and worked on; it stalls only when its own result is due.
module implicit_list_first_fit_allocator import ilffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [ADDR_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] block_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [ADDR_W-1:0] payload_address_o
);

  // Commands flow from the controller to the datapath, and status flows back.
  cmd_t cmd;
  sts_t sts;

  // The controller owns both handshakes and the state machine of the walk.
  ilffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the tag memory, the walk and merge pointers, the
  // break register and the result word that drives the output ports.
  ilffa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .func_i            (func_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .payload_address_o (payload_address_o)
  );

endmodule
